FILE: src/bba_pkg.sv
package bba_pkg;

  localparam int POOL_LEVELS = 11;
  localparam int TOP_LEVEL   = POOL_LEVELS - 1;
  localparam int UNIT_BITS   = POOL_LEVELS - 1;
  localparam int UNIT_COUNT  = 1 << UNIT_BITS;
  localparam int LINK_BITS   = UNIT_BITS + 1;
  localparam int LEVEL_BITS  = 4;
  localparam int REQ_BITS    = 24;
  localparam int TOT_BITS    = REQ_BITS + 2;
  localparam int ROUND_BYTES = 16;
  localparam int USABLE_BITS = 18;
  localparam int STATUS_BITS = 3;
  localparam int INFO_BITS   = LEVEL_BITS + 2;

  localparam logic [LINK_BITS-1:0] NO_UNIT = LINK_BITS'(UNIT_COUNT);

  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_NO_SPACE   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_ZERO_SIZE  = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_DOUBLE     = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_NOT_BLOCK  = 3'd5;

  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_CLEAR  = 4'd1;
  localparam logic [3:0] OP_LOAD   = 4'd2;
  localparam logic [3:0] OP_SCAN   = 4'd3;
  localparam logic [3:0] OP_READ_U = 4'd4;
  localparam logic [3:0] OP_UNLINK = 4'd5;
  localparam logic [3:0] OP_SPLIT1 = 4'd6;
  localparam logic [3:0] OP_PUSH2  = 4'd7;
  localparam logic [3:0] OP_GRANT  = 4'd8;
  localparam logic [3:0] OP_RCHK   = 4'd9;
  localparam logic [3:0] OP_READ_B = 4'd10;
  localparam logic [3:0] OP_MERGE  = 4'd11;
  localparam logic [3:0] OP_RPUSH1 = 4'd12;

  typedef struct packed {
    logic [3:0]             op;
    logic                   res_valid;
    logic [STATUS_BITS-1:0] res_code;
  } bba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic zero_req;
    logic too_large;
    logic head_hit;
    logic lvl_top;
    logic above_want;
    logic not_head;
    logic is_free;
    logic buddy_ok;
  } bba_stat_t;

endpackage

FILE: src/bba_ctrl.sv
module bba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  bba_pkg::bba_stat_t stat,
  output logic              busy,
  output bba_pkg::bba_cmd_t cmd
);
  import bba_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_ACHK   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_ARD    = 4'd4;
  localparam logic [3:0] S_AUNL   = 4'd5;
  localparam logic [3:0] S_SPLIT  = 4'd6;
  localparam logic [3:0] S_PUSH2A = 4'd7;
  localparam logic [3:0] S_RCHK   = 4'd8;
  localparam logic [3:0] S_MRD    = 4'd9;
  localparam logic [3:0] S_MTEST  = 4'd10;
  localparam logic [3:0] S_RPUSH  = 4'd11;
  localparam logic [3:0] S_RPUSH2 = 4'd12;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    cmd.op        = OP_NONE;
    cmd.res_valid = 1'b0;
    cmd.res_code  = ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = operation ? S_RCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (stat.zero_req) begin
          cmd.res_valid = 1'b1;
          cmd.res_code  = ST_ZERO_SIZE;
          state_next    = S_IDLE;
        end else if (stat.too_large) begin
          cmd.res_valid = 1'b1;
          cmd.res_code  = ST_TOO_LARGE;
          state_next    = S_IDLE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.head_hit) begin
          cmd.op     = OP_SCAN;
          state_next = S_ARD;
        end else if (stat.lvl_top) begin
          cmd.res_valid = 1'b1;
          cmd.res_code  = ST_NO_SPACE;
          state_next    = S_IDLE;
        end else begin
          cmd.op = OP_SCAN;
        end
      end
      S_ARD: begin
        cmd.op     = OP_READ_U;
        state_next = S_AUNL;
      end
      S_AUNL: begin
        cmd.op     = OP_UNLINK;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        if (stat.above_want) begin
          cmd.op     = OP_SPLIT1;
          state_next = S_PUSH2A;
        end else begin
          cmd.op        = OP_GRANT;
          cmd.res_valid = 1'b1;
          cmd.res_code  = ST_OK;
          state_next    = S_IDLE;
        end
      end
      S_PUSH2A: begin
        cmd.op     = OP_PUSH2;
        state_next = S_SPLIT;
      end
      S_RCHK: begin
        if (stat.not_head) begin
          cmd.res_valid = 1'b1;
          cmd.res_code  = ST_NOT_BLOCK;
          state_next    = S_IDLE;
        end else if (stat.is_free) begin
          cmd.res_valid = 1'b1;
          cmd.res_code  = ST_DOUBLE;
          state_next    = S_IDLE;
        end else begin
          cmd.op     = OP_RCHK;
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        if (stat.lvl_top) begin
          state_next = S_RPUSH;
        end else begin
          cmd.op     = OP_READ_B;
          state_next = S_MTEST;
        end
      end
      S_MTEST: begin
        if (stat.buddy_ok) begin
          cmd.op     = OP_MERGE;
          state_next = S_MRD;
        end else begin
          state_next = S_RPUSH;
        end
      end
      S_RPUSH: begin
        cmd.op     = OP_RPUSH1;
        state_next = S_RPUSH2;
      end
      S_RPUSH2: begin
        cmd.op        = OP_PUSH2;
        cmd.res_valid = 1'b1;
        cmd.res_code  = ST_OK;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/bba_dpath.sv
module bba_dpath #(
  parameter int MIN_BLOCK_LOG = 7,
  parameter int HEADER_BYTES  = 80
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bba_pkg::bba_cmd_t                   cmd,
  input  logic [bba_pkg::REQ_BITS-1:0]        request_bytes,
  input  logic [bba_pkg::UNIT_BITS-1:0]       release_unit,
  output bba_pkg::bba_stat_t                  stat,
  output logic                                done,
  output logic [bba_pkg::STATUS_BITS-1:0]     status,
  output logic [bba_pkg::UNIT_BITS-1:0]       granted_unit,
  output logic [bba_pkg::LEVEL_BITS-1:0]      granted_level,
  output logic [bba_pkg::USABLE_BITS-1:0]     usable_bytes
);
  import bba_pkg::*;

  // Per-unit info word: {level, free, head}.
  logic [INFO_BITS-1:0] info_mem [UNIT_COUNT];
  logic [LINK_BITS-1:0] next_mem [UNIT_COUNT];
  logic [LINK_BITS-1:0] prev_mem [UNIT_COUNT];
  logic [INFO_BITS-1:0] info_q;
  logic [LINK_BITS-1:0] next_q, prev_q;

  logic [LINK_BITS-1:0]  head [POOL_LEVELS];
  logic [UNIT_BITS-1:0]  u, ptr, cnt;
  logic [LEVEL_BITS-1:0] lvl, want;
  logic                  zero_req, too_large;

  logic [UNIT_BITS-1:0]  rd_addr;
  logic                  info_we, next_we, prev_we;
  logic [UNIT_BITS-1:0]  info_wa, next_wa, prev_wa;
  logic [INFO_BITS-1:0]  info_wd;
  logic [LINK_BITS-1:0]  next_wd, prev_wd;

  logic [LEVEL_BITS-1:0] lvl_dn, want_calc, q_level;
  logic [UNIT_BITS-1:0]  bit_lvl, bit_dn, buddy, lo, hi;
  logic [LINK_BITS-1:0]  head_cur;
  logic                  p_valid, n_valid, h_valid;
  logic [TOT_BITS-1:0]   total;
  logic [31:0]           blk_bytes;
  logic [USABLE_BITS-1:0] usable_calc;

  assign lvl_dn   = lvl - LEVEL_BITS'(1);
  assign bit_lvl  = UNIT_BITS'(1) << lvl;
  assign bit_dn   = UNIT_BITS'(1) << lvl_dn;
  assign buddy    = u ^ bit_lvl;
  assign lo       = u & ~bit_lvl;
  assign hi       = lo | bit_lvl;
  assign head_cur = head[lvl];
  assign h_valid  = !head_cur[UNIT_BITS];
  assign p_valid  = !prev_q[UNIT_BITS];
  assign n_valid  = !next_q[UNIT_BITS];
  assign q_level  = info_q[INFO_BITS-1:2];

  // Rounded request plus header, and the smallest level that holds it.
  always_comb begin
    total = ((TOT_BITS'(request_bytes) + TOT_BITS'(ROUND_BYTES - 1))
             & ~TOT_BITS'(ROUND_BYTES - 1)) + TOT_BITS'(HEADER_BYTES);
    want_calc = '0;
    for (int l = 0; l < TOP_LEVEL; l++) begin
      if ((TOT_BITS'(1) << (MIN_BLOCK_LOG + l)) < total) want_calc = want_calc + LEVEL_BITS'(1);
    end
  end

  always_comb begin
    blk_bytes = 32'(1) << (MIN_BLOCK_LOG + int'(lvl));
    if (blk_bytes > 32'(HEADER_BYTES)) begin
      usable_calc = USABLE_BITS'(blk_bytes - 32'(HEADER_BYTES));
    end else begin
      usable_calc = '0;
    end
  end

  assign stat.clr_last   = &cnt;
  assign stat.zero_req   = zero_req;
  assign stat.too_large  = too_large;
  assign stat.head_hit   = h_valid;
  assign stat.lvl_top    = (lvl == LEVEL_BITS'(TOP_LEVEL));
  assign stat.above_want = (lvl > want);
  assign stat.not_head   = !info_q[0];
  assign stat.is_free    = info_q[1];
  assign stat.buddy_ok   = info_q[0] && info_q[1] && (q_level == lvl);

  always_comb begin
    rd_addr = u;
    info_we = 1'b0;
    info_wa = u;
    info_wd = '0;
    next_we = 1'b0;
    next_wa = u;
    next_wd = NO_UNIT;
    prev_we = 1'b0;
    prev_wa = u;
    prev_wd = NO_UNIT;
    case (cmd.op)
      OP_CLEAR: begin
        info_we = 1'b1;
        info_wa = cnt;
        info_wd = (cnt == '0) ? {LEVEL_BITS'(TOP_LEVEL), 2'b11} : '0;
        next_we = (cnt == '0);
        next_wa = cnt;
        prev_we = (cnt == '0);
        prev_wa = cnt;
      end
      OP_LOAD:   rd_addr = release_unit;
      OP_READ_B: rd_addr = buddy;
      OP_UNLINK, OP_MERGE: begin
        next_we = p_valid;
        next_wa = prev_q[UNIT_BITS-1:0];
        next_wd = next_q;
        prev_we = n_valid;
        prev_wa = next_q[UNIT_BITS-1:0];
        prev_wd = prev_q;
        if (cmd.op == OP_MERGE) begin
          info_we = 1'b1;
          info_wa = hi;
          info_wd = '0;
        end
      end
      OP_SPLIT1: begin
        info_we = 1'b1;
        info_wa = u | bit_dn;
        info_wd = {lvl_dn, 2'b11};
        next_we = 1'b1;
        next_wa = u | bit_dn;
        next_wd = head[lvl_dn];
        prev_we = 1'b1;
        prev_wa = u | bit_dn;
      end
      OP_RPUSH1: begin
        info_we = 1'b1;
        info_wd = {lvl, 2'b11};
        next_we = 1'b1;
        next_wd = head_cur;
        prev_we = 1'b1;
      end
      OP_PUSH2: begin
        prev_we = h_valid;
        prev_wa = head_cur[UNIT_BITS-1:0];
        prev_wd = {1'b0, ptr};
      end
      OP_GRANT: begin
        info_we = 1'b1;
        info_wd = {lvl, 2'b01};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_wa] <= info_wd;
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    info_q <= info_mem[rd_addr];
    next_q <= next_mem[rd_addr];
    prev_q <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      for (int i = 0; i < POOL_LEVELS; i++) begin
        head[i] <= (i == TOP_LEVEL) ? '0 : NO_UNIT;
      end
    end else begin
      case (cmd.op)
        OP_CLEAR: cnt <= cnt + UNIT_BITS'(1);
        OP_LOAD: begin
          u         <= release_unit;
          lvl       <= want_calc;
          want      <= want_calc;
          zero_req  <= (request_bytes == '0);
          too_large <= (total > (TOT_BITS'(1) << (MIN_BLOCK_LOG + TOP_LEVEL)));
        end
        OP_SCAN: begin
          if (h_valid) begin
            u <= head_cur[UNIT_BITS-1:0];
          end else begin
            lvl <= lvl + LEVEL_BITS'(1);
          end
        end
        OP_UNLINK: begin
          if (!p_valid) head[lvl] <= next_q;
        end
        OP_MERGE: begin
          if (!p_valid) head[lvl] <= next_q;
          u   <= lo;
          lvl <= lvl + LEVEL_BITS'(1);
        end
        OP_SPLIT1: begin
          lvl <= lvl_dn;
          ptr <= u | bit_dn;
        end
        OP_RPUSH1: ptr <= u;
        OP_PUSH2:  head[lvl] <= {1'b0, ptr};
        OP_RCHK: begin
          lvl <= (q_level > LEVEL_BITS'(TOP_LEVEL)) ? LEVEL_BITS'(TOP_LEVEL) : q_level;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.res_valid;
    end
    if (cmd.res_valid) begin
      status <= cmd.res_code;
      if (cmd.res_code == ST_OK) begin
        granted_unit  <= u;
        granted_level <= lvl;
        usable_bytes  <= usable_calc;
      end else begin
        granted_unit  <= '0;
        granted_level <= '0;
        usable_bytes  <= '0;
      end
    end
  end

endmodule

FILE: src/buddy_block_allocator_unit.sv
// Binary buddy allocator; one command per start beat, one result beat per command.
// busy falls in the same cycle that done rises, and a new start beat can be taken while done is shown.
// After rst the info memory is swept one entry a cycle, with busy high; done shows
// each result beat for one cycle and the receiver cannot stall it.
module buddy_block_allocator_unit #(
  parameter int MIN_BLOCK_LOG = 7,
  parameter int HEADER_BYTES  = 80
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [bba_pkg::REQ_BITS-1:0]        request_bytes,
  input  logic [bba_pkg::UNIT_BITS-1:0]       release_unit,
  output logic                                done,
  output logic [bba_pkg::STATUS_BITS-1:0]     status,
  output logic [bba_pkg::UNIT_BITS-1:0]       granted_unit,
  output logic [bba_pkg::LEVEL_BITS-1:0]      granted_level,
  output logic [bba_pkg::USABLE_BITS-1:0]     usable_bytes
);
  import bba_pkg::*;

  // The controller sequences scan, unlink, split, merge and push steps;
  // the datapath holds the free-list heads, the link and info memories,
  // and the result register that presents each beat.
  bba_cmd_t  cmd;
  bba_stat_t stat;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Inputs are sampled only in the accept cycle, so the ports may change afterward.
  bba_dpath #(
    .MIN_BLOCK_LOG (MIN_BLOCK_LOG),
    .HEADER_BYTES  (HEADER_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .request_bytes (request_bytes),
    .release_unit  (release_unit),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .granted_unit  (granted_unit),
    .granted_level (granted_level),
    .usable_bytes  (usable_bytes)
  );

endmodule
